// ===== sv/moving_average_trend_detector_core_macros.svh =====
// Assertion helpers used by the RTL sequencer (mavtd_ctrl). Each macro expects clk and rst_n in scope.
`ifndef MOVING_AVERAGE_TREND_DETECTOR_CORE_MACROS_SVH
`define MOVING_AVERAGE_TREND_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication
`define MAVTD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MAVTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mavtd_pkg.sv =====
package mavtd_pkg;

    // Defaults for the top-level parameters
    localparam int WINDOW_MAX_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    // Fixed field widths
    localparam int IN_PRICE_W  = 32;
    localparam int OUT_PRICE_W = 32;
    localparam int WSIZE_W     = 7;
    localparam int TRIG_W      = 16;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TRIGGER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TRIGGER = 2'd2;

    // Register reset values
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd16;
    localparam logic [TRIG_W-1:0]  TRIG_RESET  = 16'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        TREND_SETTLED,
        TREND_UP,
        TREND_DOWN
    } trend_t;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic accept;   // beat taken, window written, scan armed
        logic take;     // window read data valid this cycle
        logic decide;   // apply mean comparison to trend state
        logic load;     // load result register
    } ctrl_t;

endpackage

// ===== sv/mavtd_in_if.sv =====
interface mavtd_in_if;
    logic                               valid;
    logic                               ready;
    logic [mavtd_pkg::IN_PRICE_W-1:0]   bid_price;
    logic [mavtd_pkg::IN_PRICE_W-1:0]   ask_price;

    modport source (output valid, output bid_price, output ask_price, input ready);
    modport sink   (input valid, input bid_price, input ask_price, output ready);
endinterface

// ===== sv/mavtd_out_if.sv =====
interface mavtd_out_if;
    logic                               valid;
    logic                               ready;
    logic                               inverted_trend;
    logic                               rising_trend;
    logic                               falling_trend;
    logic [mavtd_pkg::OUT_PRICE_W-1:0]  window_max_bid;
    logic [mavtd_pkg::OUT_PRICE_W-1:0]  window_min_ask;

    modport source (output valid, output inverted_trend, output rising_trend,
                    output falling_trend, output window_max_bid, output window_min_ask,
                    input ready);
    modport sink   (input valid, input inverted_trend, input rising_trend,
                    input falling_trend, input window_max_bid, input window_min_ask,
                    output ready);
endinterface

// ===== sv/mavtd_window.sv =====
// Bid/ask ring storage: one write port, one registered read port
module mavtd_window #(
    parameter int WINDOW_MAX = mavtd_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = mavtd_pkg::PRICE_BITS_DEF,
    localparam int AW = $clog2(WINDOW_MAX)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [PRICE_BITS-1:0] wbid,
    input  logic [PRICE_BITS-1:0] wask,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [PRICE_BITS-1:0] rbid,
    output logic [PRICE_BITS-1:0] rask
);

    logic [2*PRICE_BITS-1:0] mem [WINDOW_MAX];
    logic [2*PRICE_BITS-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wbid, wask};
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rbid = rdata_reg[2*PRICE_BITS-1:PRICE_BITS];
    assign rask = rdata_reg[PRICE_BITS-1:0];

endmodule

// ===== sv/mavtd_accum.sv =====
// Shared scan unit: running sum, max bid and min ask, then mean compare
module mavtd_accum #(
    parameter int WINDOW_MAX = mavtd_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = mavtd_pkg::PRICE_BITS_DEF,
    localparam int SW = $clog2(WINDOW_MAX + 1),
    localparam int SUM_W = PRICE_BITS + SW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mavtd_pkg::ctrl_t      ctl,
    input  logic [PRICE_BITS-1:0] bid,
    input  logic [SW-1:0]         n,
    input  logic [PRICE_BITS-1:0] rbid,
    input  logic [PRICE_BITS-1:0] rask,
    output logic                  gt,
    output logic                  lt,
    output logic [PRICE_BITS-1:0] max_bid,
    output logic [PRICE_BITS-1:0] min_ask
);

    logic [SUM_W-1:0]      scaled_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [PRICE_BITS-1:0] max_reg;
    logic [PRICE_BITS-1:0] min_reg;
    logic                  first_reg;

    // First-entry flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.accept)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.take)
        begin
            first_reg <= 1'b0;
        end
    end

    // Scaled newest bid and accumulators
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            scaled_reg <= {SW'(0), bid} * {PRICE_BITS'(0), n};
            sum_reg    <= '0;
        end
        else if (ctl.take)
        begin
            sum_reg <= sum_reg + {SW'(0), rbid};
            if (first_reg || (rbid > max_reg))
            begin
                max_reg <= rbid;
            end
            if (first_reg || (rask < min_reg))
            begin
                min_reg <= rask;
            end
        end
    end

    assign gt      = scaled_reg > sum_reg;
    assign lt      = scaled_reg < sum_reg;
    assign max_bid = max_reg;
    assign min_ask = min_reg;

endmodule

// ===== sv/mavtd_ctrl.sv =====
`include "moving_average_trend_detector_core_macros.svh"

// Sequencer: ring pointers, fill level, scan addressing, step strobes
module mavtd_ctrl #(
    parameter int WINDOW_MAX = mavtd_pkg::WINDOW_MAX_DEF,
    localparam int AW = $clog2(WINDOW_MAX),
    localparam int SW = $clog2(WINDOW_MAX + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick_valid,
    input  logic [SW-1:0]    n,
    input  logic             settled,
    input  logic             out_free,
    output logic             ready,
    output logic             we,
    output logic [AW-1:0]    waddr,
    output logic             re,
    output logic [AW-1:0]    raddr,
    output mavtd_pkg::ctrl_t ctl
);

    mavtd_pkg::state_t state_reg, state_next;
    logic [AW-1:0] slot_reg;
    logic [SW-1:0] fill_reg;
    logic [SW-1:0] used_reg;
    logic          decide_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [SW-1:0] cnt_reg;
    logic          take_reg;

    logic          fire;
    logic          issue;
    logic [SW-1:0] fill_inc;
    logic [SW-1:0] used_calc;
    logic [AW-1:0] slot_inc;
    logic [AW-1:0] rd_dec;

    assign fire  = tick_valid && (state_reg == mavtd_pkg::ST_IDLE);
    assign issue = (state_reg == mavtd_pkg::ST_SCAN) && (cnt_reg != used_reg);

    // Pointer arithmetic
    assign fill_inc  = (fill_reg == SW'(WINDOW_MAX)) ? fill_reg : fill_reg + SW'(1);
    assign used_calc = (fill_inc < n) ? fill_inc : n;
    assign slot_inc  = (slot_reg == AW'(WINDOW_MAX - 1)) ? '0 : slot_reg + AW'(1);
    assign rd_dec    = (rd_addr_reg == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_reg - AW'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mavtd_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    state_next = mavtd_pkg::ST_SCAN;
                end
            end
            mavtd_pkg::ST_SCAN:
            begin
                if (!issue && !take_reg)
                begin
                    state_next = mavtd_pkg::ST_DECIDE;
                end
            end
            mavtd_pkg::ST_DECIDE:
            begin
                state_next = mavtd_pkg::ST_EMIT;
            end
            mavtd_pkg::ST_EMIT:
            begin
                if (settled || out_free)
                begin
                    state_next = mavtd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mavtd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ready      = (state_reg == mavtd_pkg::ST_IDLE);
        we         = fire;
        waddr      = slot_reg;
        re         = issue;
        raddr      = rd_addr_reg;
        ctl.accept = fire;
        ctl.take   = take_reg;
        ctl.decide = (state_reg == mavtd_pkg::ST_DECIDE) && decide_reg;
        ctl.load   = (state_reg == mavtd_pkg::ST_EMIT) && !settled && out_free;
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mavtd_pkg::ST_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            used_reg    <= '0;
            decide_reg  <= 1'b0;
            rd_addr_reg <= '0;
            cnt_reg     <= '0;
            take_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            take_reg  <= issue;
            if (fire)
            begin
                slot_reg    <= slot_inc;
                fill_reg    <= fill_inc;
                used_reg    <= used_calc;
                decide_reg  <= (fill_inc >= n);
                rd_addr_reg <= slot_reg;
                cnt_reg     <= '0;
            end
            else if (issue)
            begin
                rd_addr_reg <= rd_dec;
                cnt_reg     <= cnt_reg + SW'(1);
            end
        end
    end

    `MAVTD_ASSERT_NEXT(a_fire_to_scan, fire, state_reg == mavtd_pkg::ST_SCAN, "beat did not start a scan")
    `MAVTD_ASSERT_IMPL(a_take_in_scan, take_reg, state_reg == mavtd_pkg::ST_SCAN, "read data outside scan")
    `MAVTD_ASSERT_IMPL(a_scan_bound, state_reg == mavtd_pkg::ST_SCAN, (cnt_reg <= used_reg) && (used_reg != '0), "scan count out of range")

endmodule

// ===== sv/moving_average_trend_detector_core.sv =====
// An accepted beat is written to the window; the newest used entries, used being
//   min(fill level, window size), pass one at a time through the shared scan unit,
//   and a result is loaded unless settled. Beats are taken only in idle; a held
//   result stalls the next beat only if a second result is ready before the first is taken.
// Reset: rst_n is asynchronous, active low; clears pointers, counters, trend and config
//   registers to their defaults. Window storage is not cleared and needs no clearing pass.
module moving_average_trend_detector_core #(
    parameter int WINDOW_MAX = mavtd_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = mavtd_pkg::PRICE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mavtd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mavtd_pkg::CFG_DATA_W-1:0]    cfg_data,
    mavtd_in_if.sink                            tick,
    mavtd_out_if.source                         result
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int SW    = $clog2(WINDOW_MAX + 1);
    localparam int CW    = (SW > mavtd_pkg::WSIZE_W) ? SW : mavtd_pkg::WSIZE_W;
    localparam int IN_W  = mavtd_pkg::IN_PRICE_W;
    localparam int OUT_W = mavtd_pkg::OUT_PRICE_W;
    localparam int CNT_W = mavtd_pkg::COUNT_W;

    logic [mavtd_pkg::WSIZE_W-1:0] window_size_reg;
    logic [mavtd_pkg::TRIG_W-1:0]  up_trigger_reg;
    logic [mavtd_pkg::TRIG_W-1:0]  down_trigger_reg;

    logic [CNT_W-1:0]   up_count_reg;
    logic [CNT_W-1:0]   down_count_reg;
    mavtd_pkg::trend_t  trend_reg;
    logic               differs_reg;

    logic               out_valid_reg;
    logic               inverted_reg;
    logic               up_reg;
    logic               down_reg;
    logic [OUT_W-1:0]   max_out_reg;
    logic [OUT_W-1:0]   min_out_reg;

    logic [CW-1:0]         ws_ext;
    logic [SW-1:0]         n;
    logic [PRICE_BITS-1:0] bid_in;
    logic [PRICE_BITS-1:0] ask_in;
    logic                  out_free;
    logic                  settled;
    logic                  we;
    logic                  re;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [PRICE_BITS-1:0] rbid;
    logic [PRICE_BITS-1:0] rask;
    logic                  gt;
    logic                  lt;
    logic [PRICE_BITS-1:0] max_bid;
    logic [PRICE_BITS-1:0] min_ask;
    logic [OUT_W+PRICE_BITS-1:0] max_wide;
    logic [OUT_W+PRICE_BITS-1:0] min_wide;
    logic [IN_W+PRICE_BITS-1:0]  bid_wide;
    logic [IN_W+PRICE_BITS-1:0]  ask_wide;
    mavtd_pkg::ctrl_t      ctl;

    // Effective window size: zero acts as one, clipped to storage depth
    assign ws_ext = CW'(window_size_reg);
    always_comb
    begin
        priority if (ws_ext == '0)
        begin
            n = SW'(1);
        end
        else if (ws_ext > CW'(WINDOW_MAX))
        begin
            n = SW'(WINDOW_MAX);
        end
        else
        begin
            n = ws_ext[SW-1:0];
        end
    end

    // Price width adaptation
    assign bid_wide = {PRICE_BITS'(0), tick.bid_price};
    assign ask_wide = {PRICE_BITS'(0), tick.ask_price};
    assign bid_in   = bid_wide[PRICE_BITS-1:0];
    assign ask_in   = ask_wide[PRICE_BITS-1:0];
    assign max_wide = {OUT_W'(0), max_bid};
    assign min_wide = {OUT_W'(0), min_ask};

    assign out_free = !out_valid_reg || result.ready;
    assign settled  = (trend_reg == mavtd_pkg::TREND_SETTLED);

    mavtd_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .n          (n),
        .settled    (settled),
        .out_free   (out_free),
        .ready      (tick.ready),
        .we         (we),
        .waddr      (waddr),
        .re         (re),
        .raddr      (raddr),
        .ctl        (ctl)
    );

    mavtd_window #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_window (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wbid  (bid_in),
        .wask  (ask_in),
        .re    (re),
        .raddr (raddr),
        .rbid  (rbid),
        .rask  (rask)
    );

    mavtd_accum #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .bid     (bid_in),
        .n       (n),
        .rbid    (rbid),
        .rask    (rask),
        .gt      (gt),
        .lt      (lt),
        .max_bid (max_bid),
        .min_ask (min_ask)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= mavtd_pkg::WSIZE_RESET;
            up_trigger_reg   <= mavtd_pkg::TRIG_RESET;
            down_trigger_reg <= mavtd_pkg::TRIG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mavtd_pkg::REG_WINDOW_SIZE:
                begin
                    window_size_reg <= cfg_data[mavtd_pkg::WSIZE_W-1:0];
                end
                mavtd_pkg::REG_UP_TRIGGER:
                begin
                    up_trigger_reg <= cfg_data[mavtd_pkg::TRIG_W-1:0];
                end
                mavtd_pkg::REG_DOWN_TRIGGER:
                begin
                    down_trigger_reg <= cfg_data[mavtd_pkg::TRIG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Trend state, updated once per full-window decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_count_reg   <= '0;
            down_count_reg <= '0;
            trend_reg      <= mavtd_pkg::TREND_SETTLED;
            differs_reg    <= 1'b0;
        end
        else if (ctl.decide)
        begin
            priority if (gt)
            begin
                differs_reg <= 1'b1;
                trend_reg   <= mavtd_pkg::TREND_UP;
                if (up_count_reg != '1)
                begin
                    up_count_reg <= up_count_reg + CNT_W'(1);
                end
            end
            else if (lt)
            begin
                differs_reg <= 1'b1;
                trend_reg   <= mavtd_pkg::TREND_DOWN;
                if (down_count_reg != '1)
                begin
                    down_count_reg <= down_count_reg + CNT_W'(1);
                end
            end
            else
            begin
                differs_reg    <= 1'b0;
                trend_reg      <= mavtd_pkg::TREND_SETTLED;
                up_count_reg   <= '0;
                down_count_reg <= '0;
            end
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            inverted_reg <= differs_reg;
            up_reg       <= (trend_reg == mavtd_pkg::TREND_UP) &&
                            (up_count_reg >= CNT_W'(up_trigger_reg));
            down_reg     <= (trend_reg == mavtd_pkg::TREND_DOWN) &&
                            (down_count_reg >= CNT_W'(down_trigger_reg));
            max_out_reg  <= max_wide[OUT_W-1:0];
            min_out_reg  <= min_wide[OUT_W-1:0];
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.inverted_trend = inverted_reg;
    assign result.rising_trend   = up_reg;
    assign result.falling_trend  = down_reg;
    assign result.window_max_bid = max_out_reg;
    assign result.window_min_ask = min_out_reg;

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = mavtd_pkg::WINDOW_MAX_DEF;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_TICKS = 160;
    localparam logic [mavtd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [mavtd_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [mavtd_pkg::IN_PRICE_W-1:0] price_t;

    typedef struct packed {
        logic                              inverted_trend;
        logic                              rising_trend;
        logic                              falling_trend;
        logic [mavtd_pkg::OUT_PRICE_W-1:0] window_max_bid;
        logic [mavtd_pkg::OUT_PRICE_W-1:0] window_min_ask;
    } trend_result_t;

    typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cfg_word_t              size_data;
        cfg_word_t              up_data;
        cfg_word_t              down_data;
        price_t                 bid;
        price_t                 ask;
        bit                     typed;
        trend_result_t          res;
    } quote_row_t;

    typedef enum int {MODE_NOISE, MODE_WALK, MODE_FLAT, MODE_NARROW, MODE_CORNER} quote_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [mavtd_pkg::CFG_IDX_W-1:0] cfg_index;
    cfg_word_t cfg_data;

    mavtd_in_if  tick_if ();
    mavtd_out_if res_if ();

    moving_average_trend_detector_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_if),
        .result    (res_if)
    );

    always #10 clk = ~clk;

    // Shadow of the detector: quote history, counters, trend and registers
    price_t                                bid_hist [HIST_DEPTH];
    price_t                                ask_hist [HIST_DEPTH];
    int unsigned                           hist_slot;
    int unsigned                           hist_fill;
    logic [mavtd_pkg::COUNT_W-1:0]         up_ticks;
    logic [mavtd_pkg::COUNT_W-1:0]         down_ticks;
    mavtd_pkg::trend_t                     trend_now;
    logic                                  off_mean;
    logic [mavtd_pkg::WSIZE_W-1:0]         size_reg;
    logic [mavtd_pkg::TRIG_W-1:0]          up_trig_reg;
    logic [mavtd_pkg::TRIG_W-1:0]          down_trig_reg;

    trend_result_t expected_trends [$];
    quote_row_t    directed_rows [$];
    int            fail_count;
    bit            steady_tx;
    bit            steady_rx;

    // Random quote shaping
    quote_mode_t           quote_mode;
    int                    burst_left;
    price_t                walk_bid;
    price_t                flat_bid;
    bit                    walk_rising;
    int                    walk_shift;

    // Apply one quote to the shadow state; returns 1 when a result is due
    function automatic bit predict_trend(input price_t bid,
                                         input price_t ask,
                                         output trend_result_t res);
        int unsigned n;
        int unsigned used;
        int unsigned slot;
        logic [39:0] scaled;
        logic [39:0] total;
        price_t hi_bid;
        price_t lo_ask;
        n = (size_reg == '0) ? 1 : (size_reg > HIST_DEPTH) ? HIST_DEPTH : int'(size_reg);
        bid_hist[hist_slot] = bid;
        ask_hist[hist_slot] = ask;
        hist_slot = (hist_slot + 1) % HIST_DEPTH;
        if (hist_fill < HIST_DEPTH)
            hist_fill++;
        used = (hist_fill < n) ? hist_fill : n;
        res = '0;

        // mean test without division: bid * n against the window sum
        if (hist_fill >= n)
        begin
            scaled = 40'(bid) * 40'(n);
            total = '0;
            for (int k = 0; k < n; k++)
            begin
                slot = (hist_slot + 2 * HIST_DEPTH - 1 - k) % HIST_DEPTH;
                total += 40'(bid_hist[slot]);
            end
            if (scaled > total)
            begin
                off_mean = 1'b1;
                if (up_ticks != '1)
                    up_ticks++;
                trend_now = mavtd_pkg::TREND_UP;
            end
            else if (scaled < total)
            begin
                off_mean = 1'b1;
                if (down_ticks != '1)
                    down_ticks++;
                trend_now = mavtd_pkg::TREND_DOWN;
            end
            else
            begin
                off_mean = 1'b0;
                up_ticks = '0;
                down_ticks = '0;
                trend_now = mavtd_pkg::TREND_SETTLED;
            end
        end

        if (trend_now == mavtd_pkg::TREND_SETTLED)
            return 1'b0;

        // extremes over the most recent used quotes
        hi_bid = '0;
        lo_ask = '0;
        for (int k = 0; k < used; k++)
        begin
            slot = (hist_slot + 2 * HIST_DEPTH - 1 - k) % HIST_DEPTH;
            if (k == 0 || bid_hist[slot] > hi_bid)
                hi_bid = bid_hist[slot];
            if (k == 0 || ask_hist[slot] < lo_ask)
                lo_ask = ask_hist[slot];
        end
        res.inverted_trend = off_mean;
        res.rising_trend = (trend_now == mavtd_pkg::TREND_UP) &&
                           (up_ticks >= mavtd_pkg::COUNT_W'(up_trig_reg));
        res.falling_trend = (trend_now == mavtd_pkg::TREND_DOWN) &&
                            (down_ticks >= mavtd_pkg::COUNT_W'(down_trig_reg));
        res.window_max_bid = hi_bid;
        res.window_min_ask = lo_ask;
        return 1'b1;
    endfunction

    function automatic quote_row_t tick_row(input price_t bid,
                                            input price_t ask);
        quote_row_t r;
        r = '{kind: ROW_TICK, bid: bid, ask: ask, typed: 1'b0, default: '0};
        return r;
    endfunction

    function automatic quote_row_t typed_row(input price_t bid,
                                             input price_t ask,
                                             input trend_result_t res);
        quote_row_t r;
        r = '{kind: ROW_TICK, bid: bid, ask: ask, typed: 1'b1, res: res, default: '0};
        return r;
    endfunction

    function automatic quote_row_t cfg_row(input cfg_word_t size_data,
                                           input cfg_word_t up_data,
                                           input cfg_word_t down_data);
        quote_row_t r;
        r = '{kind: ROW_CFG, size_data: size_data, up_data: up_data,
              down_data: down_data, default: '0};
        return r;
    endfunction

    // Next random quote: half trending walks, the rest flat, narrow, corner and noise bursts
    function automatic void next_quote(output price_t bid,
                                       output price_t ask);
        int pick;
        price_t step;
        if (burst_left == 0)
        begin
            pick = $urandom_range(0, 9);
            quote_mode = (pick < 2) ? MODE_NOISE : (pick < 7) ? MODE_WALK :
                         (pick == 7) ? MODE_FLAT : (pick == 8) ? MODE_NARROW : MODE_CORNER;
            burst_left = $urandom_range(4, 40);
            walk_rising = 1'($urandom_range(0, 1));
            walk_shift = $urandom_range(0, 24);
            walk_bid = $urandom;
            flat_bid = $urandom;
        end
        burst_left--;
        case (quote_mode)
            MODE_WALK:
            begin
                step = $urandom_range(0, 1 << walk_shift);
                // occasional pullback so trends cross the mean
                if (($urandom_range(0, 9) == 0) ^ walk_rising)
                    walk_bid = walk_bid + step;
                else
                    walk_bid = walk_bid - step;
                bid = walk_bid;
            end
            MODE_FLAT:   bid = flat_bid;
            MODE_NARROW: bid = walk_rising ? $urandom_range(0, 3) : ~$urandom_range(0, 3);
            MODE_CORNER:
            begin
                case ($urandom_range(0, 3))
                    0:       bid = '0;
                    1:       bid = '1;
                    2:       bid = 32'h8000_0000;
                    default: bid = 32'h7FFF_FFFF;
                endcase
            end
            default:     bid = $urandom;
        endcase
        if (quote_mode == MODE_NOISE || $urandom_range(0, 7) == 0)
            ask = $urandom;
        else
            ask = bid + $urandom_range(0, 255);
    endfunction

    // Wait until every due result has arrived and the core has gone quiet
    task automatic drain();
        tick_if.valid <= 1'b0;
        while (expected_trends.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back; optionally poke the unused index too
    task automatic program_regs(input cfg_word_t size_data,
                                input cfg_word_t up_data,
                                input cfg_word_t down_data,
                                input bit poke_unused);
        cfg_we <= 1'b1;
        cfg_index <= mavtd_pkg::REG_WINDOW_SIZE;
        cfg_data <= size_data;
        @(posedge clk);
        cfg_index <= mavtd_pkg::REG_UP_TRIGGER;
        cfg_data <= up_data;
        @(posedge clk);
        cfg_index <= mavtd_pkg::REG_DOWN_TRIGGER;
        cfg_data <= down_data;
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data <= cfg_word_t'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        size_reg = size_data[mavtd_pkg::WSIZE_W-1:0];
        up_trig_reg = up_data[mavtd_pkg::TRIG_W-1:0];
        down_trig_reg = down_data[mavtd_pkg::TRIG_W-1:0];
    endtask

    // Offer one quote beat and predict once it is taken
    task automatic send_tick(input price_t bid,
                             input price_t ask,
                             input bit typed,
                             input trend_result_t typed_res);
        int gap;
        trend_result_t res;
        if ($urandom_range(0, 39) == 0)
            steady_tx = ~steady_tx;
        gap = steady_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.bid_price <= bid;
        tick_if.ask_price <= ask;
        do
            @(posedge clk);
        while (!tick_if.ready);
        if (predict_trend(bid, ask, res))
            expected_trends.push_back(typed ? typed_res : res);
        else if (typed)
            expected_trends.push_back(typed_res);
    endtask

    function automatic void check_beat();
        trend_result_t exp_res;
        if (expected_trends.size() == 0)
        begin
            $error("unexpected result beat");
            fail_count++;
            return;
        end
        exp_res = expected_trends[0];
        expected_trends.delete(0);
        if (res_if.inverted_trend !== exp_res.inverted_trend)
        begin
            $error("inverted_trend: expected %0b, got %0b",
                   exp_res.inverted_trend, res_if.inverted_trend);
            fail_count++;
        end
        if (res_if.rising_trend !== exp_res.rising_trend)
        begin
            $error("rising_trend: expected %0b, got %0b",
                   exp_res.rising_trend, res_if.rising_trend);
            fail_count++;
        end
        if (res_if.falling_trend !== exp_res.falling_trend)
        begin
            $error("falling_trend: expected %0b, got %0b",
                   exp_res.falling_trend, res_if.falling_trend);
            fail_count++;
        end
        if (res_if.window_max_bid !== exp_res.window_max_bid)
        begin
            $error("window_max_bid: expected %h, got %h",
                   exp_res.window_max_bid, res_if.window_max_bid);
            fail_count++;
        end
        if (res_if.window_min_ask !== exp_res.window_min_ask)
        begin
            $error("window_min_ask: expected %h, got %h",
                   exp_res.window_min_ask, res_if.window_min_ask);
            fail_count++;
        end
    endfunction

    // Result side: random backpressure, plus two long hold-offs to fill the core
    initial
    begin
        int hold;
        int beats;
        hold = 0;
        beats = 0;
        steady_rx = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        res_if.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                check_beat();
                beats++;
                if ($urandom_range(0, 39) == 0)
                    steady_rx = ~steady_rx;
                hold = steady_rx ? 0 : $urandom_range(0, 3);
                if (beats == 150 || beats == 700)
                    hold = 600;
            end
            else if (hold > 0)
                hold--;
            res_if.ready <= (hold == 0);
        end
    end

    // Stimulus: directed rows, then random phases each with fresh register settings
    initial
    begin
        price_t bid;
        price_t ask;
        cfg_word_t size_data;
        cfg_word_t up_data;
        cfg_word_t down_data;
        int pick;
        cfg_word_t fixed_size [6] = '{16'd127, 16'd64, 16'd1, 16'd0, 16'd100, 16'd2};
        cfg_word_t fixed_up [6] = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF};
        cfg_word_t fixed_down [6] = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'd0};

        fail_count = 0;
        steady_tx = 1'b0;
        burst_left = 0;
        quote_mode = MODE_NOISE;
        walk_bid = '0;
        flat_bid = '0;
        walk_rising = 1'b0;
        walk_shift = 0;
        hist_slot = 0;
        hist_fill = 0;
        up_ticks = '0;
        down_ticks = '0;
        trend_now = mavtd_pkg::TREND_SETTLED;
        off_mean = 1'b0;
        size_reg = mavtd_pkg::WSIZE_RESET;
        up_trig_reg = mavtd_pkg::TRIG_RESET;
        down_trig_reg = mavtd_pkg::TRIG_RESET;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= mavtd_pkg::REG_WINDOW_SIZE;
        cfg_data <= '0;
        tick_if.valid <= 1'b0;
        tick_if.bid_price <= '0;
        tick_if.ask_price <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a 16-deep window is not yet full, so nothing comes out
        directed_rows.push_back(tick_row(32'h0000_0000, 32'hFFFF_FFFF));
        directed_rows.push_back(tick_row(32'hFFFF_FFFF, 32'h0000_0000));
        // two-deep window: equal clears, then a drop below the mean
        directed_rows.push_back(cfg_row(16'd2, 16'd1, 16'd1));
        directed_rows.push_back(tick_row(32'hFFFF_FFFF, 32'h8000_0000));
        directed_rows.push_back(typed_row(32'h0000_0000, 32'h7FFF_FFFF,
                                          '{1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF}));
        // window grown past the fill level: trend held, extremes over what is there
        directed_rows.push_back(cfg_row(16'd16, 16'd1, 16'd1));
        directed_rows.push_back(tick_row(32'h1234_5678, 32'h0000_FFFF));
        directed_rows.push_back(tick_row(32'hFFFF_0000, 32'hFFFF_0000));
        // size zero acts as one: every quote equals its own mean
        directed_rows.push_back(cfg_row(16'd0, 16'd1, 16'd1));
        directed_rows.push_back(tick_row(32'hA5A5_A5A5, 32'h5A5A_5A5A));
        directed_rows.push_back(tick_row(32'h5A5A_5A5A, 32'hA5A5_A5A5));
        // zero up trigger always met, top down trigger never
        directed_rows.push_back(cfg_row(16'd3, 16'd0, 16'hFFFF));
        directed_rows.push_back(tick_row(32'd1, 32'd2));
        directed_rows.push_back(tick_row(32'd2, 32'd3));
        directed_rows.push_back(tick_row(32'd3, 32'd4));
        directed_rows.push_back(tick_row(32'd2, 32'd1));
        directed_rows.push_back(tick_row(32'd2, 32'd1));
        directed_rows.push_back(tick_row(32'd2, 32'd1));
        // and the other way round
        directed_rows.push_back(cfg_row(16'd2, 16'hFFFF, 16'd0));
        directed_rows.push_back(tick_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_rows.push_back(typed_row(32'h0000_0000, 32'h0000_0000,
                                          '{1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000}));
        directed_rows.push_back(tick_row(32'h0000_0000, 32'h0000_0000));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain();
                program_regs(directed_rows[i].size_data, directed_rows[i].up_data,
                             directed_rows[i].down_data, 1'b0);
            end
            else
                send_tick(directed_rows[i].bid, directed_rows[i].ask,
                          directed_rows[i].typed, directed_rows[i].res);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 6)
            begin
                size_data = fixed_size[p];
                up_data = fixed_up[p];
                down_data = fixed_down[p];
            end
            else
            begin
                // small windows mostly; the long ones cost a scan step per entry
                pick = $urandom_range(0, 9);
                size_data = cfg_word_t'((pick < 6) ? $urandom_range(1, 8) :
                                        (pick < 8) ? $urandom_range(9, 40) :
                                                     $urandom_range(41, 127));
                if ($urandom_range(0, 1))
                    size_data = size_data | (cfg_word_t'($urandom) << mavtd_pkg::WSIZE_W);
                up_data = cfg_word_t'(($urandom_range(0, 4) == 0) ? $urandom :
                                                                   $urandom_range(0, 4));
                down_data = cfg_word_t'(($urandom_range(0, 4) == 0) ? $urandom :
                                                                     $urandom_range(0, 4));
            end
            drain();
            program_regs(size_data, up_data, down_data, p % 3 == 1);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                next_quote(bid, ask);
                send_tick(bid, ask, 1'b0, '0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
